// ----- design/tbu_pkg.sv -----
// ----------------------------------------------------------------------------
// tbu_pkg
// Shared widths, command codes and payload types of the transformed box union.
// ----------------------------------------------------------------------------
package tbu_pkg;

    localparam int FIELD_W   = 32;
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int AXES      = 3;
    localparam int COLS      = 4;
    localparam int COL_IDX_W = $clog2(COLS);
    localparam int PROD_W    = 2 * FIELD_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W     = TERM_W + 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_BOX  = 1'b1;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic signed [TERM_W-1:0]  term_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam sum_t   SUM_CMAX  = {{(SUM_W-COORD_W){1'b0}}, COORD_MAX};
    localparam sum_t   SUM_CMIN  = {{(SUM_W-COORD_W){1'b1}}, COORD_MIN};

    // terms indexed [row][col]
    typedef struct packed {
        term_t  [AXES-1:0][AXES-1:0] term_lo;
        term_t  [AXES-1:0][AXES-1:0] term_hi;
        field_t [AXES-1:0]           trans;
        logic                        last;
        logic                        invalid;
    } term_pkt_t;

endpackage

// ----- design/tbu_in_if.sv -----
// ----------------------------------------------------------------------------
// tbu_in_if
// Request channel: matrix column loads and boxes.
// ----------------------------------------------------------------------------
interface tbu_in_if import tbu_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [COL_IDX_W-1:0] column_index;
    field_t               col_x;
    field_t               col_y;
    field_t               col_z;
    field_t               box_min_x;
    field_t               box_min_y;
    field_t               box_min_z;
    field_t               box_max_x;
    field_t               box_max_y;
    field_t               box_max_z;
    logic                 last;

    modport source (
        output valid, cmd, column_index, col_x, col_y, col_z,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, last,
        input  ready
    );

    modport sink (
        input  valid, cmd, column_index, col_x, col_y, col_z,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, last,
        output ready
    );

endinterface

// ----- design/tbu_out_if.sv -----
// ----------------------------------------------------------------------------
// tbu_out_if
// Result channel: union bounds and group flags.
// ----------------------------------------------------------------------------
interface tbu_out_if import tbu_pkg::*; ();

    logic   valid;
    logic   ready;
    field_t union_min_x;
    field_t union_min_y;
    field_t union_min_z;
    field_t union_max_x;
    field_t union_max_y;
    field_t union_max_z;
    logic   nonempty;
    logic   overflow;
    logic   input_invalid;

    modport source (
        output valid, union_min_x, union_min_y, union_min_z,
               union_max_x, union_max_y, union_max_z, nonempty, overflow, input_invalid,
        input  ready
    );

    modport sink (
        input  valid, union_min_x, union_min_y, union_min_z,
               union_max_x, union_max_y, union_max_z, nonempty, overflow, input_invalid,
        output ready
    );

endinterface

// ----- design/transformed_box_union_top.sv -----
// Path: a last box passes the product stage register, the queue, the sum stage
// register and the fold stage before it reaches the result register.
// Throughput: one request per cycle unless the queue or result channel stalls.
// Reset clears the matrix store to zero, empties the union and flags, and
// empties the queue and all stages.
// ----------------------------------------------------------------------------
// transformed_box_union_top
// Running union of boxes transformed by a loaded 3x4 affine matrix.
// ----------------------------------------------------------------------------
module transformed_box_union_top import tbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tbu_in_if.sink    item,
    tbu_out_if.source result
);

    logic      front_valid;
    logic      front_ready;
    term_pkt_t front_pkt;
    logic      back_valid;
    logic      back_ready;
    term_pkt_t back_pkt;

    tbu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .pkt_valid (front_valid),
        .pkt_ready (front_ready),
        .pkt       (front_pkt)
    );

    tbu_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_pkt),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_pkt)
    );

    tbu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (back_valid),
        .pkt_ready (back_ready),
        .pkt       (back_pkt),
        .result    (result)
    );

endmodule

// ----- design/tbu_front.sv -----
// ----------------------------------------------------------------------------
// tbu_front
// Accepts requests, keeps the matrix store and forms the floored products of
// every element of the linear 3x3 part of the matrix with the box minimum and maximum.
// ----------------------------------------------------------------------------
module tbu_front import tbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    tbu_in_if.sink    item,
    output logic      pkt_valid,
    input  logic      pkt_ready,
    output term_pkt_t pkt
);

    field_t    matrix_reg [COLS][AXES];
    logic      stage_valid_reg;
    logic      stage_valid_next;
    term_pkt_t stage_reg;
    term_pkt_t stage_next;

    logic      accept;
    logic      is_box;
    field_t    box_lo [AXES];
    field_t    box_hi [AXES];
    field_t    col_in [AXES];

    assign item.ready = !stage_valid_reg || pkt_ready;
    assign accept     = item.valid && item.ready;
    assign is_box     = (item.cmd == CMD_BOX);

    assign box_lo[0] = item.box_min_x;
    assign box_lo[1] = item.box_min_y;
    assign box_lo[2] = item.box_min_z;
    assign box_hi[0] = item.box_max_x;
    assign box_hi[1] = item.box_max_y;
    assign box_hi[2] = item.box_max_z;
    assign col_in[0] = item.col_x;
    assign col_in[1] = item.col_y;
    assign col_in[2] = item.col_z;

    always_comb
    begin
        logic signed [PROD_W-1:0] prod_lo;
        logic signed [PROD_W-1:0] prod_hi;
        stage_next.invalid = 1'b0;
        stage_next.last    = item.last;
        for (int r = 0; r < AXES; r++)
        begin
            stage_next.trans[r] = matrix_reg[COLS-1][r];
            if (box_lo[r] > box_hi[r])
            begin
                stage_next.invalid = 1'b1;
            end
            for (int c = 0; c < AXES; c++)
            begin
                prod_lo = PROD_W'(matrix_reg[c][r]) * PROD_W'(box_lo[c]);
                prod_hi = PROD_W'(matrix_reg[c][r]) * PROD_W'(box_hi[c]);
                stage_next.term_lo[r][c] = prod_lo[PROD_W-1:FRAC_BITS];
                stage_next.term_hi[r][c] = prod_hi[PROD_W-1:FRAC_BITS];
            end
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (item.ready)
        begin
            stage_valid_next = accept && is_box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            for (int c = 0; c < COLS; c++)
            begin
                for (int r = 0; r < AXES; r++)
                begin
                    matrix_reg[c][r] <= '0;
                end
            end
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept && !is_box)
            begin
                for (int r = 0; r < AXES; r++)
                begin
                    matrix_reg[item.column_index][r] <= col_in[r];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_box)
        begin
            stage_reg <= stage_next;
        end
    end

    assign pkt_valid = stage_valid_reg;
    assign pkt       = stage_reg;

endmodule

// ----- design/tbu_fifo.sv -----
// ----------------------------------------------------------------------------
// tbu_fifo
// Short queue of product packets between the front and the back.
// ----------------------------------------------------------------------------
module tbu_fifo import tbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  term_pkt_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output term_pkt_t pop_data
);

    term_pkt_t       mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/tbu_back.sv -----
// ----------------------------------------------------------------------------
// tbu_back
// Sums the extreme corner terms per axis, saturates, folds into the running
// union and emits the union on the last box of a group.
// ----------------------------------------------------------------------------
module tbu_back import tbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_ready,
    input  term_pkt_t pkt,
    tbu_out_if.source result
);

    sum_t   s1_min_reg [AXES];
    sum_t   s1_max_reg [AXES];
    sum_t   s1_min_next [AXES];
    sum_t   s1_max_next [AXES];
    logic   s1_last_reg;
    logic   s1_invalid_reg;
    logic   s1_valid_reg;

    coord_t low_reg [AXES];
    coord_t high_reg [AXES];
    coord_t low_next [AXES];
    coord_t high_next [AXES];
    logic   ovf_seen_reg;
    logic   inv_seen_reg;
    logic   ovf_now;

    logic   out_valid_reg;
    field_t out_min_reg [AXES];
    field_t out_max_reg [AXES];
    logic   out_nonempty_reg;
    logic   out_ovf_reg;
    logic   out_inv_reg;
    logic   nonempty_next;

    logic   fold_ok;
    logic   fold;
    logic   take;

    assign fold_ok   = !s1_last_reg || !out_valid_reg || result.ready;
    assign fold      = s1_valid_reg && fold_ok;
    assign pkt_ready = !s1_valid_reg || fold_ok;
    assign take      = pkt_valid && pkt_ready;

    always_comb
    begin
        term_t a;
        term_t b;
        for (int r = 0; r < AXES; r++)
        begin
            s1_min_next[r] = {{(SUM_W-FIELD_W){pkt.trans[r][FIELD_W-1]}}, pkt.trans[r]};
            s1_max_next[r] = s1_min_next[r];
            for (int c = 0; c < AXES; c++)
            begin
                a = pkt.term_lo[r][c];
                b = pkt.term_hi[r][c];
                if (a < b)
                begin
                    s1_min_next[r] = s1_min_next[r] + {{(SUM_W-TERM_W){a[TERM_W-1]}}, a};
                    s1_max_next[r] = s1_max_next[r] + {{(SUM_W-TERM_W){b[TERM_W-1]}}, b};
                end
                else
                begin
                    s1_min_next[r] = s1_min_next[r] + {{(SUM_W-TERM_W){b[TERM_W-1]}}, b};
                    s1_max_next[r] = s1_max_next[r] + {{(SUM_W-TERM_W){a[TERM_W-1]}}, a};
                end
            end
        end
    end

    always_comb
    begin
        coord_t smin;
        coord_t smax;
        ovf_now       = 1'b0;
        nonempty_next = 1'b1;
        for (int r = 0; r < AXES; r++)
        begin
            smin = s1_min_reg[r][COORD_W-1:0];
            smax = s1_max_reg[r][COORD_W-1:0];
            if (s1_min_reg[r] < SUM_CMIN)
            begin
                smin    = COORD_MIN;
                ovf_now = 1'b1;
            end
            else if (s1_min_reg[r] > SUM_CMAX)
            begin
                smin    = COORD_MAX;
                ovf_now = 1'b1;
            end
            if (s1_max_reg[r] > SUM_CMAX)
            begin
                smax    = COORD_MAX;
                ovf_now = 1'b1;
            end
            else if (s1_max_reg[r] < SUM_CMIN)
            begin
                smax    = COORD_MIN;
                ovf_now = 1'b1;
            end
            low_next[r]  = (smin < low_reg[r])  ? smin : low_reg[r];
            high_next[r] = (smax > high_reg[r]) ? smax : high_reg[r];
            if (low_next[r] > high_next[r])
            begin
                nonempty_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ovf_seen_reg  <= 1'b0;
            inv_seen_reg  <= 1'b0;
            for (int r = 0; r < AXES; r++)
            begin
                low_reg[r]  <= COORD_MAX;
                high_reg[r] <= COORD_MIN;
            end
        end
        else
        begin
            if (pkt_ready)
            begin
                s1_valid_reg <= pkt_valid;
            end
            if (fold && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fold)
            begin
                if (s1_last_reg)
                begin
                    ovf_seen_reg <= 1'b0;
                    inv_seen_reg <= 1'b0;
                    for (int r = 0; r < AXES; r++)
                    begin
                        low_reg[r]  <= COORD_MAX;
                        high_reg[r] <= COORD_MIN;
                    end
                end
                else
                begin
                    ovf_seen_reg <= ovf_seen_reg || ovf_now;
                    inv_seen_reg <= inv_seen_reg || s1_invalid_reg;
                    low_reg      <= low_next;
                    high_reg     <= high_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_min_reg     <= s1_min_next;
            s1_max_reg     <= s1_max_next;
            s1_last_reg    <= pkt.last;
            s1_invalid_reg <= pkt.invalid;
        end
        if (fold && s1_last_reg)
        begin
            for (int r = 0; r < AXES; r++)
            begin
                out_min_reg[r] <= low_next[r][FIELD_W-1:0];
                out_max_reg[r] <= high_next[r][FIELD_W-1:0];
            end
            out_nonempty_reg <= nonempty_next;
            out_ovf_reg      <= ovf_seen_reg || ovf_now;
            out_inv_reg      <= inv_seen_reg || s1_invalid_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.union_min_x   = out_min_reg[0];
    assign result.union_min_y   = out_min_reg[1];
    assign result.union_min_z   = out_min_reg[2];
    assign result.union_max_x   = out_max_reg[0];
    assign result.union_max_y   = out_max_reg[1];
    assign result.union_max_z   = out_max_reg[2];
    assign result.nonempty      = out_nonempty_reg;
    assign result.overflow      = out_ovf_reg;
    assign result.input_invalid = out_inv_reg;

endmodule
